>>> hdl/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg: shared types and constants of the keyed stock table
// Table geometry, operation and status codes, and the command record that
// travels from the front end through the queue to the table engine.
// ----------------------------------------------------------------------------
package kst_pkg;

    localparam int TABLE_DEPTH   = 64;
    localparam int IDX_W         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);

    localparam int OP_W          = 3;
    localparam int KEY_W         = 32;
    localparam int STOCK_W       = 32;
    localparam int STATUS_W      = 3;
    localparam int TALLY_W       = 7;
    localparam int TALLY_MAX     = 127;
    localparam int SMALL_KEY_MAX = 9;

    localparam int FIFO_DEPTH    = 2;
    localparam int FPTR_W        = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FCNT_W        = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT     = 3'd0,
        OP_LOOKUP     = 3'd1,
        OP_ADJUST     = 3'd2,
        OP_LIST_ALL   = 3'd3,
        OP_COUNT      = 3'd4,
        OP_LIST_SMALL = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_EXISTS     = 3'd2,
        ST_FULL       = 3'd3,
        ST_NO_ENTRIES = 3'd4
    } status_t;

    typedef struct packed {
        op_t                       op;
        logic signed [KEY_W-1:0]   key;
        logic signed [STOCK_W-1:0] value;
    } cmd_t;

    // Queue write side and read side
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_wr_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_rd_t;

endpackage

>>> hdl/kst_req_if.sv
// ----------------------------------------------------------------------------
// kst_req_if: request channel of the keyed stock table
// Valid/ready channel carrying one operation with its key and value.
// ----------------------------------------------------------------------------
interface kst_req_if;
    import kst_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic signed [KEY_W-1:0]   key;
    logic signed [STOCK_W-1:0] value;

    modport source (output valid, output operation, output key, output value, input ready);
    modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

>>> hdl/kst_rsp_if.sv
// ----------------------------------------------------------------------------
// kst_rsp_if: response channel of the keyed stock table
// Valid/ready channel carrying one result with status, entry and tally.
// ----------------------------------------------------------------------------
interface kst_rsp_if;
    import kst_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [KEY_W-1:0]   out_key;
    logic signed [STOCK_W-1:0] out_stock;
    logic [TALLY_W-1:0]        tally;
    logic                      last;

    modport source (output valid, output status, output out_key, output out_stock,
                    output tally, output last, input ready);
    modport sink   (input valid, input status, input out_key, input out_stock,
                    input tally, input last, output ready);
endinterface

>>> hdl/kst_ram.sv
// ----------------------------------------------------------------------------
// kst_ram: generic simple dual-port RAM
// One write port, one read port with registered data held while re is low.
// ----------------------------------------------------------------------------
module kst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> hdl/kst_front.sv
// ----------------------------------------------------------------------------
// kst_front: request intake
// Accept request transactions, drop unknown operation codes and stage the
// command for the queue.
// ----------------------------------------------------------------------------
module kst_front (
    input  logic           clk,
    input  logic           rst_n,
    kst_req_if.sink        req,
    input  logic           q_full,
    output kst_pkg::q_wr_t q_wr
);
    import kst_pkg::*;

    logic stage_valid_reg;
    logic stage_valid_next;
    cmd_t stage_cmd_reg;
    cmd_t stage_cmd_next;
    logic taken;
    logic accept;
    logic op_known;

    assign taken    = stage_valid_reg && !q_full;
    assign req.ready = !stage_valid_reg || !q_full;
    assign accept   = req.valid && req.ready;

    always_comb
    begin
        op_known = req.operation inside {[OP_INSERT:OP_LIST_SMALL]};
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg && !taken;
        stage_cmd_next   = stage_cmd_reg;
        // unknown codes cause no result: drop them here
        if (accept && op_known)
        begin
            stage_valid_next     = 1'b1;
            stage_cmd_next.op    = op_t'(req.operation);
            stage_cmd_next.key   = req.key;
            stage_cmd_next.value = req.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_cmd_reg <= stage_cmd_next;
    end

    assign q_wr.valid = stage_valid_reg;
    assign q_wr.cmd   = stage_cmd_reg;
endmodule

>>> hdl/kst_cmd_fifo.sv
// ----------------------------------------------------------------------------
// kst_cmd_fifo: command queue
// Short queue that decouples request intake from the table engine.
// ----------------------------------------------------------------------------
module kst_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  kst_pkg::q_wr_t q_wr,
    output logic           q_full,
    input  logic           pop,
    output kst_pkg::q_rd_t q_rd
);
    import kst_pkg::*;

    cmd_t              mem_reg [FIFO_DEPTH];
    logic [FPTR_W-1:0] wr_ptr_reg;
    logic [FPTR_W-1:0] wr_ptr_next;
    logic [FPTR_W-1:0] rd_ptr_reg;
    logic [FPTR_W-1:0] rd_ptr_next;
    logic [FCNT_W-1:0] count_reg;
    logic [FCNT_W-1:0] count_next;
    logic              wr_en;
    logic              rd_en;

    assign q_full = (count_reg == FCNT_W'(FIFO_DEPTH));
    assign wr_en  = q_wr.valid && !q_full;
    assign rd_en  = pop && (count_reg != '0);

    assign q_rd.valid = (count_reg != '0);
    assign q_rd.cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= q_wr.cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FCNT_W'(FIFO_DEPTH))
        else $error("command queue over capacity");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("engine popped an empty command queue");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (q_full && !rd_en) |=> (count_reg == FCNT_W'(FIFO_DEPTH)))
        else $error("queue count moved while full and not read");
endmodule

>>> hdl/kst_back.sv
// ----------------------------------------------------------------------------
// kst_back: table engine
// Walk the key and stock RAMs one entry a cycle while rsp does not stall a list,
// execute the command and drive the response register.
// ----------------------------------------------------------------------------
module kst_back (
    input  logic           clk,
    input  logic           rst_n,
    input  kst_pkg::q_rd_t q_rd,
    output logic           pop,
    kst_rsp_if.source      rsp
);
    import kst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t                    state_reg, state_next;
    cmd_t                      cmd_reg, cmd_next;
    logic [CNT_W-1:0]          used_reg, used_next;
    logic [CNT_W-1:0]          issue_idx_reg, issue_idx_next;
    logic                      d_valid_reg, d_valid_next;
    logic [IDX_W-1:0]          d_idx_reg, d_idx_next;
    logic                      found_reg, found_next;
    logic [IDX_W-1:0]          slot_reg, slot_next;
    logic signed [STOCK_W-1:0] slot_stock_reg, slot_stock_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      pend_valid_reg, pend_valid_next;
    logic signed [KEY_W-1:0]   pend_key_reg, pend_key_next;
    logic signed [STOCK_W-1:0] pend_stock_reg, pend_stock_next;
    logic                      out_valid_reg, out_valid_next;
    status_t                   out_status_reg, out_status_next;
    logic signed [KEY_W-1:0]   out_key_reg, out_key_next;
    logic signed [STOCK_W-1:0] out_stock_reg, out_stock_next;
    logic [TALLY_W-1:0]        out_tally_reg, out_tally_next;
    logic                      out_last_reg, out_last_next;

    logic signed [KEY_W-1:0]   rd_key;
    logic signed [STOCK_W-1:0] rd_stock;
    logic                      ram_re;
    logic                      key_we;
    logic                      stock_we;
    logic [IDX_W-1:0]          stock_waddr;
    logic signed [STOCK_W-1:0] stock_wdata;

    logic                      is_list;
    logic                      is_search;
    logic                      match;
    logic                      can_load;
    logic                      emit_scan;
    logic                      stall;
    logic                      issue_ok;
    logic                      full;
    logic                      fin_fire;
    status_t                   fin_status;
    logic signed [KEY_W-1:0]   fin_key;
    logic signed [STOCK_W-1:0] fin_stock;
    logic [TALLY_W-1:0]        fin_tally;
    logic signed [STOCK_W-1:0] adj_sum;
    logic [CNT_W+TALLY_W-1:0]  cnt_wide;

    kst_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (used_reg[IDX_W-1:0]),
        .wdata (cmd_reg.key),
        .re    (ram_re),
        .raddr (issue_idx_reg[IDX_W-1:0]),
        .rdata (rd_key)
    );

    kst_ram #(.WIDTH(STOCK_W), .DEPTH(TABLE_DEPTH)) u_stock_ram (
        .clk   (clk),
        .we    (stock_we),
        .waddr (stock_waddr),
        .wdata (stock_wdata),
        .re    (ram_re),
        .raddr (issue_idx_reg[IDX_W-1:0]),
        .rdata (rd_stock)
    );

    always_comb
    begin
        is_list   = cmd_reg.op inside {OP_LIST_ALL, OP_LIST_SMALL};
        is_search = cmd_reg.op inside {OP_INSERT, OP_LOOKUP, OP_ADJUST};
    end

    // a signed key in 0..9 is an unsigned pattern of 9 or less
    assign match = is_list && ((cmd_reg.op == OP_LIST_ALL) ||
                   ($unsigned(rd_key) <= KEY_W'(SMALL_KEY_MAX)));

    assign can_load  = !out_valid_reg || rsp.ready;
    assign emit_scan = (state_reg == S_SCAN) && d_valid_reg && match && pend_valid_reg;
    assign stall     = emit_scan && !can_load;
    assign issue_ok  = issue_idx_reg < used_reg;
    assign ram_re    = (state_reg == S_SCAN) && !stall && issue_ok;
    assign full      = used_reg >= CNT_W'(TABLE_DEPTH);
    assign fin_fire  = (state_reg == S_FINISH) && can_load;
    assign adj_sum   = slot_stock_reg + cmd_reg.value;
    assign cnt_wide  = {{TALLY_W{1'b0}}, cnt_reg};

    always_comb
    begin
        fin_tally = (cnt_wide > (CNT_W + TALLY_W)'(TALLY_MAX)) ?
                    TALLY_W'(TALLY_MAX) : TALLY_W'(cnt_wide);
    end

    // final result of the command, and the table write it causes
    always_comb
    begin
        fin_status  = ST_OK;
        fin_key     = '0;
        fin_stock   = '0;
        key_we      = 1'b0;
        stock_we    = 1'b0;
        stock_waddr = used_reg[IDX_W-1:0];
        stock_wdata = cmd_reg.value;
        case (cmd_reg.op)
            OP_INSERT:
            begin
                fin_key = cmd_reg.key;
                if (full)
                begin
                    fin_status = ST_FULL;
                end
                else if (found_reg)
                begin
                    fin_status = ST_EXISTS;
                    fin_stock  = slot_stock_reg;
                end
                else
                begin
                    fin_stock = cmd_reg.value;
                    key_we    = fin_fire;
                    stock_we  = fin_fire;
                end
            end
            OP_LOOKUP:
            begin
                fin_key = cmd_reg.key;
                if (found_reg)
                begin
                    fin_stock = slot_stock_reg;
                end
                else
                begin
                    fin_status = ST_NOT_FOUND;
                end
            end
            OP_ADJUST:
            begin
                fin_key = cmd_reg.key;
                if (found_reg)
                begin
                    fin_stock   = adj_sum;
                    stock_we    = fin_fire;
                    stock_waddr = slot_reg;
                    stock_wdata = adj_sum;
                end
                else
                begin
                    fin_status = ST_NOT_FOUND;
                end
            end
            OP_LIST_ALL, OP_LIST_SMALL:
            begin
                if (pend_valid_reg)
                begin
                    fin_key   = pend_key_reg;
                    fin_stock = pend_stock_reg;
                end
                else
                begin
                    fin_status = ST_NO_ENTRIES;
                end
            end
            default:
            begin
                fin_status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        used_next       = used_reg;
        issue_idx_next  = issue_idx_reg;
        d_valid_next    = d_valid_reg;
        d_idx_next      = d_idx_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        slot_stock_next = slot_stock_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_key_next   = pend_key_reg;
        pend_stock_next = pend_stock_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        out_stock_next  = out_stock_reg;
        out_tally_next  = out_tally_reg;
        out_last_next   = out_last_reg;
        pop             = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_rd.valid)
                begin
                    pop             = 1'b1;
                    cmd_next        = q_rd.cmd;
                    issue_idx_next  = '0;
                    d_valid_next    = 1'b0;
                    found_next      = 1'b0;
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!stall)
                begin
                    if (issue_ok)
                    begin
                        issue_idx_next = issue_idx_reg + 1'b1;
                    end
                    d_valid_next = issue_ok;
                    d_idx_next   = issue_idx_reg[IDX_W-1:0];
                    if (d_valid_reg)
                    begin
                        if (is_search && !found_reg && (rd_key == cmd_reg.key))
                        begin
                            found_next      = 1'b1;
                            slot_next       = d_idx_reg;
                            slot_stock_next = rd_stock;
                        end
                        if ((cmd_reg.op == OP_COUNT) && (rd_stock != '0))
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                        // hold one match back so the final one can carry last
                        if (match)
                        begin
                            pend_valid_next = 1'b1;
                            pend_key_next   = rd_key;
                            pend_stock_next = rd_stock;
                        end
                    end
                    if (emit_scan)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_OK;
                        out_key_next    = pend_key_reg;
                        out_stock_next  = pend_stock_reg;
                        out_tally_next  = '0;
                        out_last_next   = 1'b0;
                    end
                    if (!issue_ok && !d_valid_reg)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (fin_fire)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = fin_status;
                    out_key_next    = fin_key;
                    out_stock_next  = fin_stock;
                    out_tally_next  = (cmd_reg.op == OP_COUNT) ? fin_tally : '0;
                    out_last_next   = 1'b1;
                    if (key_we)
                    begin
                        used_next = used_reg + 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            d_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            d_valid_reg    <= d_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        issue_idx_reg  <= issue_idx_next;
        d_idx_reg      <= d_idx_next;
        found_reg      <= found_next;
        slot_reg       <= slot_next;
        slot_stock_reg <= slot_stock_next;
        cnt_reg        <= cnt_next;
        pend_key_reg   <= pend_key_next;
        pend_stock_reg <= pend_stock_next;
        out_status_reg <= out_status_next;
        out_key_reg    <= out_key_next;
        out_stock_reg  <= out_stock_next;
        out_tally_reg  <= out_tally_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.out_key   = out_key_reg;
    assign rsp.out_stock = out_stock_reg;
    assign rsp.tally     = out_tally_reg;
    assign rsp.last      = out_last_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_pend_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == S_SCAN || state_reg == S_FINISH))
        else $error("held list entry outside a table walk");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_fire && (cmd_reg.op == OP_INSERT) && (fin_status == ST_OK)) |=>
        (used_reg == CNT_W'($past(used_reg) + 1'b1)))
        else $error("successful insert did not grow the table");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (issue_idx_reg <= used_reg))
        else $error("table walk ran past the used entries");
endmodule

>>> hdl/keyed_stock_table_core.sv
// ----------------------------------------------------------------------------
// keyed_stock_table_core: keyed stock table, top level
// Insertion-ordered (key, stock) table with a linear search per operation.
//
// Channels: req carries operation, key and value; rsp carries status,
// out_key, out_stock, tally and last. Both are valid/ready; a transaction
// moves at a rising clk edge with valid and ready high.
// Every known operation gives one response transaction with last set, except
// the two list operations, which give one per matching entry (last on the
// final one) or a single no_entries response. Codes 6 and 7 are dropped.
// One command is run per table walk, set by the single read port of the key
// and stock RAMs read one entry a cycle while a list walk is not paused on rsp.
// The only or final response is registered after the walk; a list streams earlier
// matches during the walk, each one once the next match has been read.
// A two-deep command queue lets requests be taken while a walk is running.
// When rsp stalls, the response register holds and a list walk pauses; the
// request side keeps filling the queue until it is full.
// Reset empties the table at once; the RAMs are not cleared and only written
// entries are ever read.
// ----------------------------------------------------------------------------
module keyed_stock_table_core (
    input  logic      clk,
    input  logic      rst_n,
    kst_req_if.sink   req,
    kst_rsp_if.source rsp
);
    import kst_pkg::*;

    q_wr_t q_wr;
    q_rd_t q_rd;
    logic  q_full;
    logic  pop;

    kst_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .q_full (q_full),
        .q_wr   (q_wr)
    );

    kst_cmd_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .q_full (q_full),
        .pop    (pop),
        .q_rd   (q_rd)
    );

    kst_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .q_rd  (q_rd),
        .pop   (pop),
        .rsp   (rsp)
    );
endmodule

>>> test/keyed_stock_table_checker.sv
// ----------------------------------------------------------------------------
// keyed_stock_table_checker: result predictor and comparator
// Watches the request and response channels of the keyed stock table. Keeps
// its own copy of the table, works out the responses that every accepted
// request must produce, and compares each accepted response field by field
// with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module keyed_stock_table_checker (
    input  logic clk,
    input  logic rst_n,
    kst_req_if   req,
    kst_rsp_if   rsp,
    output int   error_count,
    output int   pending,
    output int   replies_checked
);
    import kst_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        status_t                   status;
        logic signed [KEY_W-1:0]   key;
        logic signed [STOCK_W-1:0] stock;
        logic [TALLY_W-1:0]        tally;
        logic                      last;
    } reply_t;

    logic signed [KEY_W-1:0]   shelf_key   [TABLE_DEPTH];
    logic signed [STOCK_W-1:0] shelf_stock [TABLE_DEPTH];
    int                        shelf_used = 0;
    reply_t                    replies_due [$];
    int                        errors  = 0;
    int                        checked = 0;

    function automatic reply_t make_reply(input status_t status,
                                          input logic signed [KEY_W-1:0] key,
                                          input logic signed [STOCK_W-1:0] stock,
                                          input logic [TALLY_W-1:0] tally,
                                          input logic last);
        reply_t r;
        r.status = status;
        r.key    = key;
        r.stock  = stock;
        r.tally  = tally;
        r.last   = last;
        return r;
    endfunction

    // Slot holding the key, or shelf_used when absent
    function automatic int find_shelf(input logic signed [KEY_W-1:0] key);
        for (int i = 0; i < shelf_used; i++)
        begin
            if (shelf_key[i] == key)
                return i;
        end
        return shelf_used;
    endfunction

    function automatic void queue_listing(input bit small_only);
        int     hits;
        reply_t tail;
        hits = 0;
        for (int i = 0; i < shelf_used; i++)
        begin
            if (small_only && (shelf_key[i] < 0 || shelf_key[i] > SMALL_KEY_MAX))
                continue;
            replies_due.push_back(make_reply(ST_OK, shelf_key[i], shelf_stock[i], '0, 1'b0));
            hits++;
        end
        if (hits == 0)
        begin
            replies_due.push_back(make_reply(ST_NO_ENTRIES, '0, '0, '0, 1'b1));
        end
        else
        begin
            // mark the final entry of the walk
            tail = replies_due.pop_back();
            tail.last = 1'b1;
            replies_due.push_back(tail);
        end
    endfunction

    function automatic void predict_replies(input logic [OP_W-1:0] code,
                                            input logic signed [KEY_W-1:0] key,
                                            input logic signed [STOCK_W-1:0] value);
        int slot;
        int live;
        case (code)
            OP_INSERT:
            begin
                slot = find_shelf(key);
                // full check wins over the duplicate check
                if (shelf_used >= TABLE_DEPTH)
                    replies_due.push_back(make_reply(ST_FULL, key, '0, '0, 1'b1));
                else if (slot < shelf_used)
                    replies_due.push_back(make_reply(ST_EXISTS, key, shelf_stock[slot], '0, 1'b1));
                else
                begin
                    shelf_key[shelf_used]   = key;
                    shelf_stock[shelf_used] = value;
                    shelf_used++;
                    replies_due.push_back(make_reply(ST_OK, key, value, '0, 1'b1));
                end
            end
            OP_LOOKUP, OP_ADJUST:
            begin
                slot = find_shelf(key);
                if (slot >= shelf_used)
                begin
                    replies_due.push_back(make_reply(ST_NOT_FOUND, key, '0, '0, 1'b1));
                end
                else
                begin
                    if (code == OP_ADJUST)
                        shelf_stock[slot] = shelf_stock[slot] + value;
                    replies_due.push_back(make_reply(ST_OK, key, shelf_stock[slot], '0, 1'b1));
                end
            end
            OP_LIST_ALL:
                queue_listing(1'b0);
            OP_LIST_SMALL:
                queue_listing(1'b1);
            OP_COUNT:
            begin
                live = 0;
                for (int i = 0; i < shelf_used; i++)
                begin
                    if (shelf_stock[i] != 0)
                        live++;
                end
                if (live > TALLY_MAX)
                    live = TALLY_MAX;
                replies_due.push_back(make_reply(ST_OK, '0, '0, live[TALLY_W-1:0], 1'b1));
            end
            default:
                ; // spare codes are dropped
        endcase
    endfunction

    function automatic void check_reply();
        reply_t want;
        if (replies_due.size() == 0)
        begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("unexpected transaction: status %0d key %0d stock %0d tally %0d last %0b",
                         rsp.status, rsp.out_key, rsp.out_stock, rsp.tally, rsp.last);
            return;
        end
        want = replies_due.pop_front();
        checked++;
        if (rsp.status !== want.status || rsp.out_key !== want.key ||
            rsp.out_stock !== want.stock || rsp.tally !== want.tally ||
            rsp.last !== want.last)
        begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("result %0d: expected status %0d key %0d stock %0d tally %0d last %0b, %s",
                         checked, want.status, want.key, want.stock, want.tally, want.last,
                         $sformatf("got status %0d key %0d stock %0d tally %0d last %0b",
                                   rsp.status, rsp.out_key, rsp.out_stock, rsp.tally,
                                   rsp.last));
        end
    endfunction

    // Retire responses before predicting, so a request never meets its own results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shelf_used = 0;
            replies_due.delete();
            pending     <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                check_reply();
            if (req.valid && req.ready)
                predict_replies(req.operation, req.key, req.value);
            pending         <= replies_due.size();
            error_count     <= errors;
            replies_checked <= checked;
        end
    end

endmodule

>>> test/keyed_stock_table_core_tb.sv
// ----------------------------------------------------------------------------
// keyed_stock_table_core_tb: testbench top of the keyed stock table
// Drives directed and random operations into the table with bursty request
// traffic and a patterned response stall, including one long output hold-off
// and pauses until the table has answered everything. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module keyed_stock_table_core_tb;
    import kst_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 248;
    localparam int HOLD_AT      = 40;
    localparam int DRAIN_AT     = 70;
    localparam int FILL_AT      = 100;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 150;
    localparam int CYCLE_LIMIT  = 1000000;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam logic signed [KEY_W-1:0] WORD_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] WORD_MAX = {1'b0, {(KEY_W-1){1'b1}}};
    localparam logic signed [KEY_W-1:0] WORD_ONES = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   cycle_count = 0;
    int   error_count;
    int   results_pending;
    int   replies_checked;
    int   items_sent = 0;
    int   burst_left = 0;
    bit   drain_next = 1'b0;
    bit   hold_wanted = 1'b0;
    bit   hold_done = 1'b0;

    logic signed [KEY_W-1:0] keys_stocked [$];

    kst_req_if req ();
    kst_rsp_if rsp ();

    keyed_stock_table_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    keyed_stock_table_checker stock_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req),
        .rsp             (rsp),
        .error_count     (error_count),
        .pending         (results_pending),
        .replies_checked (replies_checked)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, results_pending);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic bit key_known(input logic signed [KEY_W-1:0] key);
        foreach (keys_stocked[i])
        begin
            if (keys_stocked[i] == key)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45 && keys_stocked.size() > 0)
            return keys_stocked[$urandom_range(0, keys_stocked.size() - 1)];
        if (roll < 65)
            return $urandom_range(0, SMALL_KEY_MAX + 5) - 2;
        if (roll < 72)
            return roll[0] ? WORD_MIN : WORD_MAX;
        return $urandom();
    endfunction

    function automatic logic signed [STOCK_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            return '0;
        if (roll < 30)
            return WORD_MIN;
        if (roll < 35)
            return WORD_MAX;
        if (roll < 40)
            return WORD_ONES;
        return $urandom();
    endfunction

    function automatic logic [OP_W-1:0] pick_code();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 28) return OP_INSERT;
        if (roll < 46) return OP_LOOKUP;
        if (roll < 68) return OP_ADJUST;
        if (roll < 74) return OP_LIST_ALL;
        if (roll < 84) return OP_COUNT;
        if (roll < 94) return OP_LIST_SMALL;
        return roll[0] ? OP_SPARE_LO : OP_SPARE_HI;
    endfunction

    // Called at the edge that accepted a transaction: keep valid up inside a
    // burst, otherwise drop it for a gap or until everything has come back
    task automatic pace_sender();
        if (drain_next)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
            while (results_pending != 0)
                @(posedge clk);
            drain_next = 1'b0;
        end
        else if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            req.valid <= 1'b0;
            if ($urandom_range(0, 99) < 15)
                repeat ($urandom_range(15, 60)) @(posedge clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic send_request(input logic [OP_W-1:0] code,
                                input logic signed [KEY_W-1:0] key,
                                input logic signed [STOCK_W-1:0] value);
        req.valid     <= 1'b1;
        req.operation <= code;
        req.key       <= key;
        req.value     <= value;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        items_sent++;
        if (code == OP_INSERT && keys_stocked.size() < TABLE_DEPTH && !key_known(key))
            keys_stocked.push_back(key);
        pace_sender();
    endtask

    // Response stall: stretches of always-ready, coin-flip, periodic and
    // mostly-ready, plus one long hold-off when the stimulus asks for it
    initial
    begin : rsp_stall_pattern
        int mode;
        int stretch;
        int period;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(20, 200);
            period  = $urandom_range(2, 5);
            for (int c = 0; c < stretch; c++)
            begin
                @(posedge clk);
                if (hold_wanted && !hold_done)
                begin
                    rsp.ready <= 1'b0;
                    repeat (HOLD_CYCLES - 1) @(posedge clk);
                    hold_done = 1'b1;
                end
                else
                begin
                    case (mode)
                        0: rsp.ready <= 1'b1;
                        1: rsp.ready <= 1'($urandom_range(0, 1));
                        2: rsp.ready <= (c % period) == 0;
                        default: rsp.ready <= $urandom_range(0, 99) < 85;
                    endcase
                end
            end
        end
    end

    initial
    begin : stimulus
        int                      n;
        logic [OP_W-1:0]         code;
        logic signed [KEY_W-1:0] key;
        req.valid     <= 1'b0;
        req.operation <= OP_COUNT;
        req.key       <= '0;
        req.value     <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // empty table: count, both lists, misses
        send_request(OP_COUNT, '0, '0);
        send_request(OP_LIST_ALL, '0, '0);
        send_request(OP_LIST_SMALL, '0, '0);
        send_request(OP_LOOKUP, 5, '0);
        send_request(OP_ADJUST, 5, 3);
        // inserts at the field extremes and around the small-key bounds
        send_request(OP_INSERT, 0, WORD_MAX);
        send_request(OP_INSERT, WORD_MIN, WORD_MIN);
        send_request(OP_INSERT, 9, '0);
        send_request(OP_INSERT, 10, WORD_ONES);
        send_request(OP_INSERT, WORD_ONES, 1);
        send_request(OP_INSERT, 9, 77);
        send_request(OP_LOOKUP, 9, '0);
        send_request(OP_LOOKUP, WORD_MAX, '0);
        // wrap both ways, cancel to zero, adjust by the extremes
        send_request(OP_ADJUST, 0, 1);
        send_request(OP_ADJUST, WORD_MIN, WORD_ONES);
        send_request(OP_ADJUST, 10, 1);
        send_request(OP_ADJUST, 9, WORD_MAX);
        send_request(OP_ADJUST, WORD_ONES, WORD_MIN);
        send_request(OP_COUNT, '0, '0);
        send_request(OP_LIST_ALL, '0, '0);
        send_request(OP_LIST_SMALL, '0, '0);
        send_request(OP_SPARE_LO, 3, 4);
        send_request(OP_SPARE_HI, WORD_ONES, WORD_ONES);
        send_request(OP_INSERT, WORD_MAX, WORD_ONES);
        drain_next = 1'b1;
        send_request(OP_LOOKUP, WORD_MAX, '0);

        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            if (n == HOLD_AT && !hold_wanted)
            begin
                // back-to-back requests while the output is held off
                hold_wanted = 1'b1;
                burst_left  = 20;
            end
            if (n == DRAIN_AT || n == RANDOM_ITEMS - 1)
                drain_next = 1'b1;
            if (n == FILL_AT)
            begin
                // fill the table with fresh keys, then keep going while full
                while (keys_stocked.size() < TABLE_DEPTH)
                begin
                    do
                        key = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SMALL_KEY_MAX)
                                                          : $urandom();
                    while (key_known(key));
                    if (keys_stocked.size() == TABLE_DEPTH - 1)
                        drain_next = 1'b1;
                    send_request(OP_INSERT, key, pick_value());
                    n++;
                end
            end
            code = pick_code();
            send_request(code, pick_key(), pick_value());
            if (code != OP_SPARE_LO && code != OP_SPARE_HI)
                n++;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d requests over all six operations and the spare codes; %0d results checked",
                 items_sent, replies_checked);
        $display("Table ran full at %0d entries; output held off for %0d cycles under load",
                 keys_stocked.size(), HOLD_CYCLES);
        if (error_count == 0 && results_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
hdl/kst_pkg.sv
hdl/kst_req_if.sv
hdl/kst_rsp_if.sv
hdl/kst_ram.sv
hdl/kst_front.sv
hdl/kst_cmd_fifo.sv
hdl/kst_back.sv
hdl/keyed_stock_table_core.sv
test/keyed_stock_table_checker.sv
test/keyed_stock_table_core_tb.sv
